FILE: rtl/assert_macros.svh
// Assertion macros used by the top level of the hash table unit.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Implication checked at every rising edge, idle while reset is low
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
// Same check, also evaluated while reset is held
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: rtl/qph_pkg.sv
// Shared types and constants of the quadratic probing hash table unit.
// No dependencies; used by the controller, the datapath and the top level.
package qph_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int KEY_WIDTH_DEF = 31;
  localparam int REQ_W         = 2;
  localparam int IDX_W         = 4;

  // request operation codes; code 3 is unused and always fails
  typedef enum logic [REQ_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch the request
    logic mod_step;  // one step of the home slot reduction
    logic probe;     // run the probe sequence
    logic clear;     // clear one valid bit
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mod_done;    // this reduction step is the last one
    logic hit;         // probe data matched (empty slot or equal key)
    logic exhausted;   // all probes examined without a hit
    logic clear_last;  // last slot of the clearing pass
  } sts_t;

endpackage

FILE: rtl/qph_ctrl.sv
// Sequencer of the hash table unit: clearing pass, home slot reduction,
// probe sequence and result strobe. Depends on qph_pkg.
module qph_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          res_strobe,
  output qph_pkg::cmd_t cmd,
  input  qph_pkg::sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLEAR = 5'b00010,
    S_MOD   = 5'b00100,
    S_PROBE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_MOD;
      S_CLEAR: if (sts.clear_last) state_nxt = S_IDLE;
      S_MOD:   if (sts.mod_done) state_nxt = S_PROBE;
      S_PROBE: if (sts.hit || sts.exhausted) state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands
  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == S_IDLE) && start;
    cmd.mod_step = (state_r == S_MOD);
    cmd.probe    = (state_r == S_PROBE);
    cmd.clear    = (state_r == S_CLEAR);
  end

  assign busy       = (state_r != S_IDLE);
  assign res_strobe = (state_r == S_DONE);

endmodule

FILE: rtl/qph_datapath.sv
// Datapath of the hash table unit: request registers, key reduction four bits a cycle
// (a slice for a power of two), quadratic probe address stepping, key and valid
// memories, result registers. Depends on qph_pkg.
module qph_datapath #(
  parameter int SLOTS     = qph_pkg::SLOTS_DEF,
  parameter int KEY_WIDTH = qph_pkg::KEY_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  qph_pkg::cmd_t               cmd,
  output qph_pkg::sts_t               sts,
  input  logic [qph_pkg::REQ_W-1:0]   req_type,
  input  logic [KEY_WIDTH-1:0]        key,
  output logic                        res_status,
  output logic [qph_pkg::IDX_W-1:0]   res_slot
);

  localparam int  SW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int  CW      = $clog2(SLOTS + 1);
  localparam int  DIG     = 4;
  localparam int  DGW     = $clog2(DIG);
  localparam int  ND      = (KEY_WIDTH + DIG - 1) / DIG;
  localparam int  KP      = ND * DIG;
  localparam int  DW      = (ND > 1) ? $clog2(ND) : 1;
  localparam int  KX      = (KEY_WIDTH > SW) ? KEY_WIDTH : SW;
  localparam int  SXW     = (SW > qph_pkg::IDX_W) ? SW : qph_pkg::IDX_W;
  localparam bit  IS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);
  localparam logic [SW:0] SLOTS_X = (SW + 1)'(SLOTS);

  logic [qph_pkg::REQ_W-1:0] op_r;
  logic [KEY_WIDTH-1:0]      key_r;
  logic [DW-1:0]             dig_r;
  logic [SW-1:0]             rem_r;
  logic [SW-1:0]             slot_r;
  logic [SW-1:0]             step_r;
  logic [CW-1:0]             cnt_r;
  logic                      rd_pend_r;
  logic [SW-1:0]             rd_slot_r;
  logic [SW-1:0]             clr_cnt_r;
  logic [KEY_WIDTH-1:0]      rd_key_r;
  logic                      rd_valid_r;

  logic [KEY_WIDTH-1:0] key_mem   [SLOTS];
  logic                 valid_mem [SLOTS];

  logic [SW:0]     rem_sum, slot_sum, step_sum;
  logic [SW-1:0]   rem_acc, rem_step, slot_step, step_step;
  logic [KX-1:0]   key_ext;
  logic [KP-1:0]   key_pad;
  logic [DIG-1:0]  digit;
  logic [SXW-1:0]  slot_ext;
  logic            cnt_full, issue, match, hit;

  // home slot: remainder four key bits a cycle, top digit first,
  // or a plain slice for a power of two
  assign key_ext = KX'(key_r);
  assign key_pad = KP'(key_r);
  assign digit   = key_pad[{dig_r, DGW'(0)} +: DIG];
  always_comb begin
    rem_acc = rem_r;
    rem_sum = '0;
    for (int b = DIG - 1; b >= 0; b--) begin
      rem_sum = {rem_acc, digit[b]};
      if (rem_sum >= SLOTS_X) rem_sum = rem_sum - SLOTS_X;
      rem_acc = rem_sum[SW-1:0];
    end
    rem_step = IS_POW2 ? key_ext[SW-1:0] : rem_acc;
  end
  assign sts.mod_done = IS_POW2 || (dig_r == '0);

  // next probe: slot += step (mod SLOTS), step += 2 (mod SLOTS)
  always_comb begin
    slot_sum = {1'b0, slot_r} + {1'b0, step_r};
    if (slot_sum >= SLOTS_X) slot_sum = slot_sum - SLOTS_X;
    slot_step = slot_sum[SW-1:0];
    step_sum = {1'b0, step_r} + (SW + 1)'(2);
    if (step_sum >= SLOTS_X) step_sum = step_sum - SLOTS_X;
    step_step = step_sum[SW-1:0];
  end

  assign cnt_full = (cnt_r == CW'(SLOTS));
  assign issue    = cmd.probe && !cnt_full;

  // compare the slot read in the previous cycle
  always_comb begin
    unique case (qph_pkg::op_t'(op_r))
      qph_pkg::OP_INSERT: match = !rd_valid_r;
      qph_pkg::OP_SEARCH,
      qph_pkg::OP_DELETE: match = rd_valid_r && (rd_key_r == key_r);
      default:            match = 1'b0;
    endcase
  end
  assign hit = rd_pend_r && match;

  assign sts.hit        = hit;
  assign sts.exhausted  = cnt_full && !rd_pend_r;
  assign sts.clear_last = (clr_cnt_r == SW'(SLOTS - 1));

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
      cnt_r     <= '0;
      clr_cnt_r <= '0;
      dig_r     <= '0;
    end else begin
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + SW'(1);
      if (cmd.load) begin
        dig_r     <= DW'(ND - 1);
        rd_pend_r <= 1'b0;
      end else if (cmd.mod_step) begin
        dig_r <= dig_r - DW'(1);
        if (sts.mod_done) cnt_r <= '0;
      end else begin
        rd_pend_r <= issue;
        if (issue) cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  // request and probe address registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= req_type;
      key_r <= key;
      rem_r <= '0;
    end
    if (cmd.mod_step) begin
      rem_r <= rem_step;
      if (sts.mod_done) begin
        slot_r <= rem_step;
        step_r <= SW'(1);
      end
    end
    if (issue) begin
      slot_r <= slot_step;
      step_r <= step_step;
    end
  end

  // memories: registered read at the probe address
  always_ff @(posedge clk) begin
    rd_key_r   <= key_mem[slot_r];
    rd_valid_r <= valid_mem[slot_r];
    rd_slot_r  <= slot_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      valid_mem[clr_cnt_r] <= 1'b0;
    end else if (cmd.probe && hit) begin
      if (qph_pkg::op_t'(op_r) == qph_pkg::OP_INSERT) begin
        valid_mem[rd_slot_r] <= 1'b1;
      end else if (qph_pkg::op_t'(op_r) == qph_pkg::OP_DELETE) begin
        valid_mem[rd_slot_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe && hit && (qph_pkg::op_t'(op_r) == qph_pkg::OP_INSERT)) begin
      key_mem[rd_slot_r] <= key_r;
    end
  end

  // result registers
  assign slot_ext = SXW'(rd_slot_r);
  always_ff @(posedge clk) begin
    if (cmd.probe && (hit || sts.exhausted)) begin
      res_status <= hit ? qph_pkg::ST_OK : qph_pkg::ST_FAIL;
      res_slot   <= hit ? slot_ext[qph_pkg::IDX_W-1:0] : '0;
    end
  end

endmodule

FILE: rtl/quadratic_probe_hash_table_unit.sv
// Quadratic probing hash table. An accepted request first reduces its key to a home slot:
// a plain slice when SLOTS is a power of two, else key mod SLOTS, 4 bits a cycle; then it
// probes until a hit or until all SLOTS probes miss (one memory read a cycle), and strobes.
// A new request is taken only while busy is low; busy stays high until the strobe has passed.
// After reset a clearing pass over all SLOTS slots empties the valid memory with busy
// high. Results are shown for one cycle; the receiver cannot stall.
`include "assert_macros.svh"
module quadratic_probe_hash_table_unit #(
  parameter int SLOTS     = qph_pkg::SLOTS_DEF,
  parameter int KEY_WIDTH = qph_pkg::KEY_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [qph_pkg::REQ_W-1:0] in_req_type,
  input  logic [KEY_WIDTH-1:0]      in_key,
  output logic                      out_strobe,
  output logic                      out_status,
  output logic [qph_pkg::IDX_W-1:0] out_slot_index
);

  qph_pkg::cmd_t cmd;
  qph_pkg::sts_t sts;

  qph_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .res_strobe (out_strobe),
    .cmd        (cmd),
    .sts        (sts)
  );

  qph_datapath #(
    .SLOTS     (SLOTS),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .req_type   (in_req_type),
    .key        (in_key),
    .res_status (out_status),
    .res_slot   (out_slot_index)
  );

  // checks
  `ASSERT_CLK(a_accept_busy, clk, rst_n, (start && !busy) |=> busy)
  `ASSERT_CLK(a_strobe_single, clk, rst_n, out_strobe |=> (!out_strobe && !busy))
  `ASSERT_CLK(a_fail_slot_zero, clk, rst_n,
    (out_strobe && (out_status == qph_pkg::ST_FAIL)) |-> (out_slot_index == '0))
  `ASSERT_ALWAYS(a_strobe_busy, clk, out_strobe |-> busy)

endmodule

FILE: test/quadratic_probe_hash_table_unit_test.sv
// Self-checking testbench for quadratic_probe_hash_table_unit: a directed table, then random
// insert/search/delete traffic checked against a behavioral copy of the slot table.
// Depends on qph_pkg and the RTL of the unit; reads no files.
module quadratic_probe_hash_table_unit_test;

  localparam int SLOTS          = qph_pkg::SLOTS_DEF;
  localparam int KEY_W          = qph_pkg::KEY_WIDTH_DEF;
  localparam int REQ_W          = qph_pkg::REQ_W;
  localparam int IDX_W          = qph_pkg::IDX_W;
  localparam int RANDOM_ITEMS   = 1750;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOT_KEYS       = 8;
  localparam logic [REQ_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MAX   = {KEY_W{1'b1}};

  typedef struct packed {
    logic             status;
    logic [IDX_W-1:0] slot;
  } lookup_result_t;

  // one row of the directed table; typed rows carry their expected answer
  typedef struct packed {
    logic [REQ_W-1:0] op;
    logic [KEY_W-1:0] key;
    logic             typed;
    logic             status;
    logic [IDX_W-1:0] slot;
  } directed_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic [REQ_W-1:0]     in_req_type = '0;
  logic [KEY_W-1:0]     in_key = '0;
  logic                 busy;
  logic                 out_strobe;
  logic                 out_status;
  logic [IDX_W-1:0]     out_slot_index;

  // behavioral copy of the slot table
  logic [KEY_W-1:0]     table_key [SLOTS];
  logic                 table_used [SLOTS];

  lookup_result_t       expected_results [$];
  lookup_result_t       oldest_result;
  logic [KEY_W-1:0]     hot_keys [HOT_KEYS];
  int                   idle_pct = 19;
  int                   error_count = 0;
  int                   idle_cycles = 0;

  directed_row_t directed_rows [] = '{
    '{qph_pkg::OP_SEARCH, 31'd0,        1'b1, qph_pkg::ST_FAIL, 4'd0},   // empty table
    '{qph_pkg::OP_DELETE, KEY_MAX,      1'b1, qph_pkg::ST_FAIL, 4'd0},
    '{OP_UNUSED,          31'd5,        1'b1, qph_pkg::ST_FAIL, 4'd0},
    '{qph_pkg::OP_INSERT, 31'd0,        1'b1, qph_pkg::ST_OK,   4'd0},
    '{qph_pkg::OP_INSERT, KEY_MAX,      1'b1, qph_pkg::ST_OK,   4'd15},
    '{qph_pkg::OP_SEARCH, KEY_MAX,      1'b1, qph_pkg::ST_OK,   4'd15},
    '{qph_pkg::OP_INSERT, 31'd16,       1'b0, qph_pkg::ST_OK,   4'd0},   // collides at home 0
    '{qph_pkg::OP_INSERT, 31'd32,       1'b0, qph_pkg::ST_OK,   4'd0},
    '{qph_pkg::OP_INSERT, 31'd0,        1'b0, qph_pkg::ST_OK,   4'd0},   // duplicate key
    '{qph_pkg::OP_DELETE, 31'd0,        1'b0, qph_pkg::ST_OK,   4'd0},
    '{qph_pkg::OP_SEARCH, 31'd0,        1'b0, qph_pkg::ST_OK,   4'd0},   // probe past freed slot
    '{qph_pkg::OP_SEARCH, 31'd48,       1'b0, qph_pkg::ST_OK,   4'd0},
    '{qph_pkg::OP_INSERT, 31'd48,       1'b0, qph_pkg::ST_OK,   4'd0},
    '{qph_pkg::OP_INSERT, 31'd64,       1'b0, qph_pkg::ST_OK,   4'd0},   // chain of home 0 full
    '{OP_UNUSED,          31'd0,        1'b1, qph_pkg::ST_FAIL, 4'd0},   // unused code, key present
    '{qph_pkg::OP_INSERT, 31'h2AAAAAAA, 1'b0, qph_pkg::ST_OK,   4'd0},
    '{qph_pkg::OP_SEARCH, 31'h55555555, 1'b0, qph_pkg::ST_OK,   4'd0},
    '{qph_pkg::OP_DELETE, KEY_MAX,      1'b1, qph_pkg::ST_OK,   4'd15},
    '{qph_pkg::OP_DELETE, KEY_MAX,      1'b1, qph_pkg::ST_FAIL, 4'd0},
    '{qph_pkg::OP_SEARCH, 31'h2AAAAAAA, 1'b0, qph_pkg::ST_OK,   4'd0}
  };

  quadratic_probe_hash_table_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_key        (in_key),
    .out_strobe    (out_strobe),
    .out_status    (out_status),
    .out_slot_index(out_slot_index)
  );

  always #2 clk = ~clk;

  // apply one request to the table copy and return its answer
  function automatic lookup_result_t apply_to_table(input logic [REQ_W-1:0] op,
                                                    input logic [KEY_W-1:0] key);
    lookup_result_t res;
    int             home;
    int             s;
    res.status = qph_pkg::ST_FAIL;
    res.slot   = '0;
    home = int'(key % SLOTS);
    for (int i = 0; i < SLOTS; i++) begin
      s = (home + i * i) % SLOTS;
      if (op == qph_pkg::OP_INSERT && !table_used[s]) begin
        table_used[s] = 1'b1;
        table_key[s]  = key;
        res.status    = qph_pkg::ST_OK;
        res.slot      = s[IDX_W-1:0];
        break;
      end
      // search and delete scan the whole chain, empty slots included
      if ((op == qph_pkg::OP_SEARCH || op == qph_pkg::OP_DELETE) &&
          table_used[s] && table_key[s] == key) begin
        if (op == qph_pkg::OP_DELETE) table_used[s] = 1'b0;
        res.status = qph_pkg::ST_OK;
        res.slot   = s[IDX_W-1:0];
        break;
      end
    end
    return res;
  endfunction

  // present one request, wait until busy is low, record the expected answer
  task automatic send_request(input logic [REQ_W-1:0] op, input logic [KEY_W-1:0] key,
                              input logic typed, input lookup_result_t typed_res);
    lookup_result_t predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_req_type <= op;
    in_key      <= key;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = apply_to_table(op, key);
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  // keys picked from the live table keep search and delete hitting
  function automatic logic [KEY_W-1:0] pick_key();
    int                used_slots [$];
    int                r;
    logic [KEY_W-1:0]  k;
    for (int s = 0; s < SLOTS; s++)
      if (table_used[s]) used_slots.push_back(s);
    r = $urandom_range(0, 99);
    k = KEY_W'($urandom());
    if (r < 45 && used_slots.size() != 0)
      k = table_key[used_slots[$urandom_range(0, used_slots.size() - 1)]];
    else if (r < 85)
      k = hot_keys[$urandom_range(0, HOT_KEYS - 1)];
    else if (r < 90)
      k = KEY_MAX;
    else if (r < 94)
      k = '0;
    return k;
  endfunction

  // main stimulus
  initial begin
    lookup_result_t    typed_res;
    logic [REQ_W-1:0]  op;
    int                insert_pct;
    int                home_base;
    int                r;
    for (int s = 0; s < SLOTS; s++) begin
      table_key[s]  = '0;
      table_used[s] = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_rows[i]) begin
      typed_res.status = directed_rows[i].status;
      typed_res.slot   = directed_rows[i].slot;
      send_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].typed,
                   typed_res);
    end

    // random traffic in segments; each segment gets its own hot keys and insert bias
    insert_pct = 50;
    typed_res  = '0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        insert_pct = $urandom_range(20, 75);
        home_base  = $urandom_range(0, SLOTS - 1);
        foreach (hot_keys[h]) begin
          hot_keys[h] = KEY_W'($urandom());
          hot_keys[h][IDX_W-1:0] = IDX_W'(home_base + $urandom_range(0, 2));
        end
      end
      if (n < RANDOM_ITEMS / 3) idle_pct = 19;
      else if (n < 2 * RANDOM_ITEMS / 3) idle_pct = 53;
      else idle_pct = 0;
      r = $urandom_range(0, 99);
      if (r < insert_pct) begin
        op = qph_pkg::OP_INSERT;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 47) op = qph_pkg::OP_SEARCH;
        else if (r < 94) op = qph_pkg::OP_DELETE;
        else op = OP_UNUSED;
      end
      send_request(op, pick_key(), 1'b0, typed_res);
    end
    start <= 1'b0;

    // drain
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: out_status %0d out_slot_index %0d", out_status,
               out_slot_index);
        error_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        if (out_status !== oldest_result.status) begin
          $error("out_status mismatch: expected %0d, actual %0d", oldest_result.status,
                 out_status);
          error_count++;
        end
        if (out_slot_index !== oldest_result.slot) begin
          $error("out_slot_index mismatch: expected %0d, actual %0d", oldest_result.slot,
                 out_slot_index);
          error_count++;
        end
      end
    end
  end

  // watchdog: too long with no request accepted and no result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
